// File: src/pileup_nucleotide_diversity_assert.svh
// ----------------------------------------------------------------------------
// Pileup nucleotide diversity assertion macros
// Shared macros for the concurrent assertions of the diversity block.
// ----------------------------------------------------------------------------
`ifndef PILEUP_NUCLEOTIDE_DIVERSITY_ASSERT_SVH
`define PILEUP_NUCLEOTIDE_DIVERSITY_ASSERT_SVH

// Assertion that is switched off while reset is asserted.
`define PND_ASSERT_RST(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// Assertion that is checked at every clock edge.
`define PND_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/pnd_pkg.sv
// ----------------------------------------------------------------------------
// Pileup nucleotide diversity package
// Widths, character codes, base decoding and controller interface types.
// ----------------------------------------------------------------------------
package pnd_pkg;

  localparam int COUNT_BITS    = 16;
  localparam int FRACTION_BITS = 16;

  localparam int NUM_BASES = 5;
  localparam int DEPTH_W   = 16;
  localparam int LOCI_W    = 32;
  localparam int N_W       = COUNT_BITS + 3;
  localparam int CMP_W     = (N_W > DEPTH_W) ? N_W : DEPTH_W;
  localparam int MUL_W     = 2 * N_W;
  localparam int DIV_W     = (MUL_W > LOCI_W) ? MUL_W : LOCI_W;
  localparam int QUO_W     = FRACTION_BITS + 1;
  localparam int SUM_W     = FRACTION_BITS + 33;
  localparam int STEP_W    = $clog2(FRACTION_BITS + 1);

  localparam logic [DEPTH_W-1:0] DEPTH_RESET = 16'd10;
  localparam logic [DEPTH_W-1:0] DEPTH_FLOOR = 16'd2;
  localparam int                 MUL_LAST    = 6;

  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_A_UC  = 8'h41;
  localparam logic [7:0] CHAR_A_LC  = 8'h61;
  localparam logic [7:0] CHAR_C_UC  = 8'h43;
  localparam logic [7:0] CHAR_C_LC  = 8'h63;
  localparam logic [7:0] CHAR_G_UC  = 8'h47;
  localparam logic [7:0] CHAR_G_LC  = 8'h67;
  localparam logic [7:0] CHAR_T_UC  = 8'h54;
  localparam logic [7:0] CHAR_T_LC  = 8'h74;

  typedef enum logic [2:0] {
    BASE_MATCH = 3'd0,
    BASE_A     = 3'd1,
    BASE_C     = 3'd2,
    BASE_G     = 3'd3,
    BASE_T     = 3'd4,
    BASE_OTHER = 3'd5
  } base_e;

  typedef struct packed {
    logic              count_char;
    logic              load_sum;
    logic              mul_step;
    logic [STEP_W-1:0] step;
    logic              div_load_locus;
    logic              div_load_report;
    logic              div_step;
    logic              emit_locus;
    logic              emit_report;
    logic              clear_locus;
  } pnd_cmd_t;

  typedef struct packed {
    logic deep_enough;
    logic out_free;
  } pnd_status_t;

  function automatic base_e base_class(input logic [7:0] ch);
    base_e cls;
    unique case (ch)
      CHAR_DOT, CHAR_COMMA:   cls = BASE_MATCH;
      CHAR_A_UC, CHAR_A_LC:   cls = BASE_A;
      CHAR_C_UC, CHAR_C_LC:   cls = BASE_C;
      CHAR_G_UC, CHAR_G_LC:   cls = BASE_G;
      CHAR_T_UC, CHAR_T_LC:   cls = BASE_T;
      default:                cls = BASE_OTHER;
    endcase
    return cls;
  endfunction

endpackage

// File: src/pileup_nucleotide_diversity.sv
// ----------------------------------------------------------------------------
// Pileup nucleotide diversity
// Per-locus nucleotide diversity from pileup base characters, with mean report.
// ----------------------------------------------------------------------------
// The input channel carries one word per pileup base character, or a report
// request when func_i is high. The output channel carries per-locus diversity
// words and report words. Both use valid and stall; the receiver drives stall.
// A character that does not end a locus is counted without stalling the
// input. A locus end that is shallower than the depth threshold passes
// through a depth sum and returns to idle. A deep enough locus end holds
// the input through a depth sum, a multiplier pass for six pair products, a
// divider load, FRACTION_BITS + 1 quotient bits at one per cycle and an
// output state. A report loads the divider on acceptance and holds the input
// through the quotient bits and the output state. While the receiver stalls,
// a finished word sits in the output register; characters keep flowing in,
// and the next result waits until the register is free. The depth threshold
// is written through its own valid and ready channel, which is always ready.
// Reset clears the base counters, the loci count and the running sum,
// empties the output register and sets the depth threshold to 10.
// ----------------------------------------------------------------------------
module pileup_nucleotide_diversity
  import pnd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [DEPTH_W-1:0] cfg_least_depth_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               func_i,
  input  logic [7:0]         base_char_i,
  input  logic               last_of_locus_i,
  input  logic [LOCI_W-1:0]  locus_position_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               kind_o,
  output logic [LOCI_W-1:0]  position_out_o,
  output logic [QUO_W-1:0]   locus_diversity_o,
  output logic [LOCI_W-1:0]  loci_counted_o,
  output logic [QUO_W-1:0]   mean_pi_o,
  output logic               count_overflow_o
);

  pnd_cmd_t    cmd;
  pnd_status_t status;

  assign cfg_ready_o = 1'b1;

  pnd_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .func_i          (func_i),
    .last_of_locus_i (last_of_locus_i),
    .status_i        (status),
    .cmd_o           (cmd),
    .in_stall_o      (in_stall_o)
  );

  pnd_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .cfg_valid_i       (cfg_valid_i && cfg_ready_o),
    .cfg_least_depth_i (cfg_least_depth_i),
    .base_char_i       (base_char_i),
    .locus_position_i  (locus_position_i),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .kind_o            (kind_o),
    .position_out_o    (position_out_o),
    .locus_diversity_o (locus_diversity_o),
    .loci_counted_o    (loci_counted_o),
    .mean_pi_o         (mean_pi_o),
    .count_overflow_o  (count_overflow_o)
  );

endmodule

// File: src/pnd_ctrl.sv
// ----------------------------------------------------------------------------
// Pileup nucleotide diversity controller
// Sequences base counting, depth check, pair products, division and output.
// ----------------------------------------------------------------------------
module pnd_ctrl
  import pnd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        func_i,
  input  logic        last_of_locus_i,
  input  pnd_status_t status_i,
  output pnd_cmd_t    cmd_o,
  output logic        in_stall_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SUM  = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_LOAD = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              report_q, report_d;
  logic              accept;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    state_d  = state_q;
    step_d   = step_q;
    report_d = report_q;
    cmd_o    = '0;
    cmd_o.step = step_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          report_d = func_i;
          if (func_i) begin
            cmd_o.div_load_report = 1'b1;
            step_d  = '0;
            state_d = ST_DIV;
          end else begin
            cmd_o.count_char = 1'b1;
            if (last_of_locus_i) begin
              state_d = ST_SUM;
            end
          end
        end
      end
      ST_SUM: begin
        cmd_o.load_sum = 1'b1;
        step_d = '0;
        if (status_i.deep_enough) begin
          state_d = ST_MUL;
        end else begin
          cmd_o.clear_locus = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_MUL: begin
        cmd_o.mul_step = 1'b1;
        if (step_q == STEP_W'(MUL_LAST)) begin
          state_d = ST_LOAD;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_LOAD: begin
        cmd_o.div_load_locus = 1'b1;
        step_d  = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (step_q == STEP_W'(FRACTION_BITS)) begin
          state_d = ST_DONE;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          if (report_q) begin
            cmd_o.emit_report = 1'b1;
          end else begin
            cmd_o.emit_locus  = 1'b1;
            cmd_o.clear_locus = 1'b1;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      step_q   <= '0;
      report_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      step_q   <= step_d;
      report_q <= report_d;
    end
  end

endmodule

// File: src/pnd_div.sv
// ----------------------------------------------------------------------------
// Pileup nucleotide diversity divider
// Restoring divider producing one quotient bit per cycle while step_i is high.
// ----------------------------------------------------------------------------
module pnd_div
  import pnd_pkg::*;
(
  input  logic             clk_i,
  input  logic             load_i,
  input  logic             step_i,
  input  logic [DIV_W-1:0] rem_init_i,
  input  logic [QUO_W-1:0] low_init_i,
  input  logic [DIV_W-1:0] den_i,
  output logic [QUO_W-1:0] quo_o
);

  logic [DIV_W-1:0] rem_q, rem_d;
  logic [QUO_W-1:0] low_q, low_d;
  logic [DIV_W-1:0] den_q, den_d;
  logic [QUO_W-1:0] quo_q, quo_d;
  logic [DIV_W:0]   trial;
  logic [DIV_W:0]   diff;
  logic             fits;

  assign trial = {rem_q, low_q[QUO_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = (trial >= {1'b0, den_q});

  always_comb begin
    rem_d = rem_q;
    low_d = low_q;
    den_d = den_q;
    quo_d = quo_q;
    if (load_i) begin
      rem_d = rem_init_i;
      low_d = low_init_i;
      den_d = den_i;
      quo_d = '0;
    end else if (step_i) begin
      rem_d = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      low_d = {low_q[QUO_W-2:0], 1'b0};
      quo_d = {quo_q[QUO_W-2:0], fits};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    low_q <= low_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign quo_o = quo_q;

endmodule

// File: src/pnd_dp.sv
// ----------------------------------------------------------------------------
// Pileup nucleotide diversity datapath
// Base counters, pair products, divider, running totals and output register.
// ----------------------------------------------------------------------------
module pnd_dp
  import pnd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pnd_cmd_t           cmd_i,
  output pnd_status_t        status_o,
  input  logic               cfg_valid_i,
  input  logic [DEPTH_W-1:0] cfg_least_depth_i,
  input  logic [7:0]         base_char_i,
  input  logic [LOCI_W-1:0]  locus_position_i,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output logic               kind_o,
  output logic [LOCI_W-1:0]  position_out_o,
  output logic [QUO_W-1:0]   locus_diversity_o,
  output logic [LOCI_W-1:0]  loci_counted_o,
  output logic [QUO_W-1:0]   mean_pi_o,
  output logic               count_overflow_o
);

  logic [DEPTH_W-1:0]    least_depth_q;
  logic [COUNT_BITS-1:0] cnt_q [NUM_BASES];
  logic                  sat_q;
  logic [LOCI_W-1:0]     pos_q;
  logic [N_W-1:0]        n_q;
  logic [MUL_W-1:0]      prod_q;
  logic [MUL_W-1:0]      sub_q;
  logic [MUL_W-1:0]      total_q;
  logic [LOCI_W-1:0]     loci_q;
  logic [SUM_W-1:0]      sum_q;

  logic                  out_valid_q;
  logic                  kind_q;
  logic [LOCI_W-1:0]     position_q;
  logic [QUO_W-1:0]      diversity_q;
  logic [LOCI_W-1:0]     counted_q;
  logic [QUO_W-1:0]      mean_q;
  logic                  overflow_q;

  base_e                 cls;
  logic [N_W-1:0]        n_sum;
  logic [DEPTH_W-1:0]    thr;
  logic [N_W-1:0]        mul_a;
  logic [N_W-1:0]        mul_a_m1;
  logic [MUL_W-1:0]      prod_d;
  logic [MUL_W-1:0]      num;
  logic                  use_report;
  logic [DIV_W-1:0]      rem_init;
  logic [QUO_W-1:0]      low_init;
  logic [DIV_W-1:0]      den;
  logic [QUO_W-1:0]      quo;
  logic                  loci_full;
  logic [SUM_W:0]        sum_ext;
  logic [SUM_W-1:0]      sum_d;

  assign cls = base_class(base_char_i);

  always_comb begin
    n_sum = '0;
    for (int i = 0; i < NUM_BASES; i++) begin
      n_sum = n_sum + N_W'(cnt_q[i]);
    end
  end

  assign thr = (least_depth_q < DEPTH_FLOOR) ? DEPTH_FLOOR : least_depth_q;
  assign status_o.deep_enough = (CMP_W'(n_sum) >= CMP_W'(thr));
  assign status_o.out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    unique case (cmd_i.step)
      STEP_W'(0): mul_a = N_W'(cnt_q[0]);
      STEP_W'(1): mul_a = N_W'(cnt_q[1]);
      STEP_W'(2): mul_a = N_W'(cnt_q[2]);
      STEP_W'(3): mul_a = N_W'(cnt_q[3]);
      STEP_W'(4): mul_a = N_W'(cnt_q[4]);
      default:    mul_a = n_q;
    endcase
  end

  assign mul_a_m1 = mul_a - N_W'(1);
  assign prod_d   = MUL_W'(mul_a) * MUL_W'(mul_a_m1);

  // The locus quotient is (num << FRACTION_BITS) / den, split into a high
  // remainder seed and the bits shifted in one per step.
  assign num        = total_q - sub_q;
  assign use_report = cmd_i.div_load_report;
  assign rem_init   = use_report ? DIV_W'(sum_q >> QUO_W) : DIV_W'(num >> 1);
  assign low_init   = use_report ? sum_q[QUO_W-1:0] : {num[0], {FRACTION_BITS{1'b0}}};
  assign den        = use_report ? DIV_W'(loci_q) : DIV_W'(total_q);

  pnd_div u_div (
    .clk_i      (clk_i),
    .load_i     (cmd_i.div_load_locus || cmd_i.div_load_report),
    .step_i     (cmd_i.div_step),
    .rem_init_i (rem_init),
    .low_init_i (low_init),
    .den_i      (den),
    .quo_o      (quo)
  );

  assign loci_full = (loci_q == {LOCI_W{1'b1}});
  assign sum_ext   = {1'b0, sum_q} + (SUM_W + 1)'(quo);
  assign sum_d     = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      least_depth_q <= DEPTH_RESET;
      for (int i = 0; i < NUM_BASES; i++) begin
        cnt_q[i] <= '0;
      end
      sat_q       <= 1'b0;
      loci_q      <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        least_depth_q <= cfg_least_depth_i;
      end
      if (cmd_i.clear_locus) begin
        for (int i = 0; i < NUM_BASES; i++) begin
          cnt_q[i] <= '0;
        end
        sat_q <= 1'b0;
      end else if (cmd_i.count_char) begin
        for (int i = 0; i < NUM_BASES; i++) begin
          if (3'(i) == 3'(cls)) begin
            if (cnt_q[i] == {COUNT_BITS{1'b1}}) begin
              sat_q <= 1'b1;
            end else begin
              cnt_q[i] <= cnt_q[i] + 1'b1;
            end
          end
        end
      end
      if (cmd_i.emit_locus && !loci_full) begin
        loci_q <= loci_q + 1'b1;
        sum_q  <= sum_d;
      end
      if (cmd_i.emit_locus || cmd_i.emit_report) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.count_char) begin
      pos_q <= locus_position_i;
    end
    if (cmd_i.load_sum) begin
      n_q   <= n_sum;
      sub_q <= '0;
    end
    if (cmd_i.mul_step) begin
      prod_q <= prod_d;
      if ((cmd_i.step >= STEP_W'(1)) && (cmd_i.step < STEP_W'(MUL_LAST))) begin
        sub_q <= sub_q + prod_q;
      end
      if (cmd_i.step == STEP_W'(MUL_LAST)) begin
        total_q <= prod_q;
      end
    end
    if (cmd_i.emit_locus) begin
      kind_q      <= 1'b0;
      position_q  <= pos_q;
      diversity_q <= quo;
      counted_q   <= loci_full ? loci_q : loci_q + 1'b1;
      mean_q      <= '0;
      overflow_q  <= sat_q || loci_full;
    end else if (cmd_i.emit_report) begin
      kind_q      <= 1'b1;
      position_q  <= '0;
      diversity_q <= '0;
      counted_q   <= loci_q;
      mean_q      <= (loci_q == '0) ? '0 : quo;
      overflow_q  <= loci_full;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign kind_o            = kind_q;
  assign position_out_o    = position_q;
  assign locus_diversity_o = diversity_q;
  assign loci_counted_o    = counted_q;
  assign mean_pi_o         = mean_q;
  assign count_overflow_o  = overflow_q;

endmodule

// File: src/pnd_checker.sv
// ----------------------------------------------------------------------------
// Pileup nucleotide diversity checker
// Port-level assertions on the output channel and the report sequence.
// ----------------------------------------------------------------------------
`include "pileup_nucleotide_diversity_assert.svh"

module pnd_checker
  import pnd_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              func_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic              kind_o,
  input logic [LOCI_W-1:0] position_out_o,
  input logic [QUO_W-1:0]  locus_diversity_o,
  input logic [LOCI_W-1:0] loci_counted_o,
  input logic [QUO_W-1:0]  mean_pi_o,
  input logic              count_overflow_o
);

  localparam logic [QUO_W-1:0] ONE_Q = {1'b1, {FRACTION_BITS{1'b0}}};

  logic out_held;
  logic in_report;
  logic report_clean;
  logic locus_ok;

  assign out_held     = out_valid_o && out_stall_i;
  assign in_report    = in_valid_i && !in_stall_o && func_i;
  assign report_clean = (position_out_o == '0) && (locus_diversity_o == '0);
  assign locus_ok     = (mean_pi_o == '0) && (locus_diversity_o <= ONE_Q);

  property p_word_hold;
    out_held |=> $stable(kind_o) && $stable(position_out_o) &&
      $stable(locus_diversity_o) && $stable(loci_counted_o) &&
      $stable(mean_pi_o) && $stable(count_overflow_o);
  endproperty

  `PND_ASSERT_RST(a_out_valid_hold, clk_i, rst_ni, out_held |=> out_valid_o, "Word dropped")

  `PND_ASSERT_RST(a_out_word_hold, clk_i, rst_ni, p_word_hold, "Word changed while stalled")

  `PND_ASSERT_RST(a_report_fields, clk_i, rst_ni, out_valid_o && kind_o |-> report_clean, "Bad report")

  `PND_ASSERT_ALWAYS(a_locus_fields, clk_i, rst_ni && out_valid_o && !kind_o |-> locus_ok, "Bad locus")

  `PND_ASSERT_RST(a_report_busy, clk_i, rst_ni, in_report |=> in_stall_o, "Report not busy")

endmodule

bind pileup_nucleotide_diversity pnd_checker u_checker (.*);
